FILE: hw/rtl/nopf_pkg.sv
// Shared types and constants for the neighbor outlier pixel filter.
// Used by nopf_ctrl, nopf_dpath and the top level.
package nopf_pkg;

   localparam int DEF_MAX_WIDTH  = 1024;
   localparam int DEF_MAX_HEIGHT = 1024;

   localparam int CFG_DIM_W  = 11;
   localparam int CFG_THR_W  = 8;
   localparam int CSR_IDX_W  = 2;
   localparam int PIX_W      = 8;
   localparam int FILT_W     = 16;

   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_WIDTH   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_HEIGHT  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_LOW_THRESHOLD = 2'd2;

   localparam logic OP_PIXEL = 1'b0;
   localparam logic OP_DRAIN = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RD_P,
      ST_RD_U,
      ST_RD_D,
      ST_RD_L,
      ST_RD_R,
      ST_CAP,
      ST_CALC1,
      ST_CALC2,
      ST_OUT
   } state_type;

   typedef enum logic [2:0] {
      SEL_CENTER,
      SEL_UP,
      SEL_DOWN,
      SEL_LEFT,
      SEL_RIGHT
   } nb_sel_type;

   typedef struct packed {
      logic       take;
      logic       rd_en;
      nb_sel_type rd_sel;
      logic       calc1;
      logic       calc2;
      logic       out_load;
   } cmd_type;

   typedef struct packed {
      logic emit;
      logic out_free;
   } status_type;

endpackage

FILE: hw/rtl/nopf_ctrl.sv
// Controller state machine for the neighbor outlier pixel filter.
// Depends on nopf_pkg; drives nopf_dpath through cmd_type.
module nopf_ctrl import nopf_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      cmd        = '0;
      cmd.rd_sel = SEL_CENTER;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.take = 1'b1;
               if (status.emit) state_in = ST_RD_P;
            end
         end
         ST_RD_P: begin
            cmd.rd_en = 1'b1;
            cmd.rd_sel = SEL_CENTER;
            state_in = ST_RD_U;
         end
         ST_RD_U: begin
            cmd.rd_en = 1'b1;
            cmd.rd_sel = SEL_UP;
            state_in = ST_RD_D;
         end
         ST_RD_D: begin
            cmd.rd_en = 1'b1;
            cmd.rd_sel = SEL_DOWN;
            state_in = ST_RD_L;
         end
         ST_RD_L: begin
            cmd.rd_en = 1'b1;
            cmd.rd_sel = SEL_LEFT;
            state_in = ST_RD_R;
         end
         ST_RD_R: begin
            cmd.rd_en = 1'b1;
            cmd.rd_sel = SEL_RIGHT;
            state_in = ST_CAP;
         end
         ST_CAP: begin
            state_in = ST_CALC1;
         end
         ST_CALC1: begin
            cmd.calc1 = 1'b1;
            state_in = ST_CALC2;
         end
         ST_CALC2: begin
            cmd.calc2 = 1'b1;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RD_R) |=> (state_ff == ST_CAP))
      else $error("read sequence broken");
   assert property (@(posedge clock) disable iff (reset)
      cmd.take |-> (state_ff == ST_IDLE))
      else $error("item taken while busy");
   assert property (@(posedge clock) disable iff (reset)
      (cmd.take && status.emit) |=> (state_ff == ST_RD_P))
      else $error("emit not started");

endmodule

FILE: hw/rtl/nopf_dpath.sv
// Datapath for the neighbor outlier pixel filter: counters, line stores,
// neighbor capture, average and outlier test, output register. Uses nopf_pkg.
module nopf_dpath import nopf_pkg::*; #(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_DIM_W-1:0] csr_wdata,
   input  logic                 req_op,
   input  logic [PIX_W-1:0]     req_pixel,
   input  cmd_type              cmd,
   output status_type           status,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [FILT_W-1:0]    rsp_filtered,
   output logic                 rsp_replaced,
   output logic                 rsp_eof
);

   localparam int CW = $clog2(MAX_WIDTH + 1);
   localparam int RW = $clog2(MAX_HEIGHT + 1);
   localparam int DEPTH = 3 * MAX_WIDTH;
   localparam int AW = $clog2(DEPTH);
   localparam logic [AW-1:0] SPAN = AW'(MAX_WIDTH);

   logic [CFG_DIM_W-1:0] width_cfg_ff, height_cfg_ff;
   logic [CFG_THR_W-1:0] thr_ff;
   logic [CW-1:0] w_eff;
   logic [RW-1:0] h_eff;

   logic [CW-1:0] in_col_ff, out_col_ff, pend_ff;
   logic [RW-1:0] in_row_ff, out_row_ff;
   logic [1:0]    in_slot_ff, out_slot_ff;

   logic [PIX_W-1:0] row_store_ff [DEPTH];
   logic [PIX_W-1:0] rd_data_ff;
   logic             cap_en_ff;
   nb_sel_type       cap_sel_ff;
   logic [PIX_W-1:0] p_ff, u_ff, d_ff, l_ff, r_ff;

   logic [9:0]  sum_ff;
   logic [2:0]  n_ff;
   logic        vu_ff, vd_ff, vl_ff, vr_ff;
   logic        farther_ff;
   logic [19:0] prod_ff;

   logic              rsp_valid_ff, replaced_ff, eof_ff;
   logic [FILT_W-1:0] filtered_ff;

   // ---------------- configuration ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         width_cfg_ff  <= CFG_DIM_W'(640);
         height_cfg_ff <= CFG_DIM_W'(480);
         thr_ff        <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            REG_IMAGE_WIDTH:   width_cfg_ff  <= csr_wdata;
            REG_IMAGE_HEIGHT:  height_cfg_ff <= csr_wdata;
            REG_LOW_THRESHOLD: thr_ff        <= csr_wdata[CFG_THR_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (width_cfg_ff == '0) w_eff = CW'(1);
      else if (32'(width_cfg_ff) > MAX_WIDTH) w_eff = CW'(MAX_WIDTH);
      else w_eff = CW'(width_cfg_ff);
      if (height_cfg_ff == '0) h_eff = RW'(1);
      else if (32'(height_cfg_ff) > MAX_HEIGHT) h_eff = RW'(MAX_HEIGHT);
      else h_eff = RW'(height_cfg_ff);
   end

   function automatic logic [PIX_W-1:0] thresh(input logic [PIX_W-1:0] v,
                                                input logic [CFG_THR_W-1:0] t);
      thresh = (v <= t) ? '0 : v;
   endfunction

   function automatic logic [AW-1:0] slot_base(input logic [1:0] s);
      logic [AW-1:0] b;
      case (s)
         2'd1:    b = SPAN;
         2'd2:    b = AW'(SPAN + SPAN);
         default: b = '0;
      endcase
      slot_base = b;
   endfunction

   function automatic logic [1:0] slot_next(input logic [1:0] s);
      slot_next = (s == 2'd2) ? 2'd0 : s + 2'd1;
   endfunction

   // ---------------- position counters ----------------
   logic at_start, clr, col_wrap_in, row_wrap_in, col_wrap_out, row_wrap_out;
   logic out_has_left, out_has_right, out_has_up, out_has_down;

   assign at_start = (in_row_ff == '0) && (in_col_ff == '0);
   assign clr      = at_start && (pend_ff != '0);
   assign status.emit = (req_op == OP_DRAIN) ? clr : (!clr && (pend_ff >= w_eff));
   assign status.out_free = !rsp_valid_ff || rsp_ready;

   assign col_wrap_in  = ({1'b0, in_col_ff} + 1'b1) >= {1'b0, w_eff};
   assign row_wrap_in  = ({1'b0, in_row_ff} + 1'b1) >= {1'b0, h_eff};
   assign col_wrap_out = ({1'b0, out_col_ff} + 1'b1) >= {1'b0, w_eff};
   assign row_wrap_out = ({1'b0, out_row_ff} + 1'b1) >= {1'b0, h_eff};

   assign out_has_up    = out_row_ff != '0;
   assign out_has_down  = !row_wrap_out;
   assign out_has_left  = out_col_ff != '0;
   assign out_has_right = !col_wrap_out;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_col_ff   <= '0;
         in_row_ff   <= '0;
         in_slot_ff  <= '0;
         out_col_ff  <= '0;
         out_row_ff  <= '0;
         out_slot_ff <= '0;
         pend_ff     <= '0;
      end else if (cmd.take) begin
         if (req_op == OP_DRAIN) begin
            if (clr) pend_ff <= pend_ff - 1'b1;
         end else begin
            if (clr) begin
               pend_ff     <= CW'(1);
               out_col_ff  <= '0;
               out_row_ff  <= '0;
               out_slot_ff <= '0;
            end else if (pend_ff < w_eff) begin
               pend_ff <= pend_ff + 1'b1;
            end
            if (col_wrap_in) begin
               in_col_ff <= '0;
               if (row_wrap_in) begin
                  in_row_ff  <= '0;
                  in_slot_ff <= '0;
               end else begin
                  in_row_ff  <= in_row_ff + 1'b1;
                  in_slot_ff <= slot_next(in_slot_ff);
               end
            end else begin
               in_col_ff <= in_col_ff + 1'b1;
            end
         end
      end else if (cmd.out_load) begin
         if (col_wrap_out) begin
            out_col_ff <= '0;
            if (row_wrap_out) begin
               out_row_ff  <= '0;
               out_slot_ff <= '0;
            end else begin
               out_row_ff  <= out_row_ff + 1'b1;
               out_slot_ff <= slot_next(out_slot_ff);
            end
         end else begin
            out_col_ff <= out_col_ff + 1'b1;
         end
      end
   end

   // ---------------- line stores ----------------
   logic [AW-1:0] wr_addr, rd_addr;
   logic [1:0]    rd_slot;
   logic [CW-1:0] rd_col;

   assign wr_addr = slot_base(in_slot_ff) + AW'(in_col_ff);

   always_comb begin
      rd_slot = out_slot_ff;
      rd_col  = out_col_ff;
      case (cmd.rd_sel)
         SEL_UP:    rd_slot = slot_next(slot_next(out_slot_ff));
         SEL_DOWN:  rd_slot = slot_next(out_slot_ff);
         SEL_LEFT:  if (out_has_left) rd_col = out_col_ff - 1'b1;
         SEL_RIGHT: if (out_has_right) rd_col = out_col_ff + 1'b1;
         default: ;
      endcase
   end

   assign rd_addr = slot_base(rd_slot) + AW'(rd_col);

   always_ff @(posedge clock) begin
      if (cmd.take && (req_op == OP_PIXEL)) row_store_ff[wr_addr] <= req_pixel;
      if (cmd.rd_en) rd_data_ff <= row_store_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_en_ff <= 1'b0;
      end else begin
         cap_en_ff <= cmd.rd_en;
      end
   end

   always_ff @(posedge clock) begin
      cap_sel_ff <= cmd.rd_sel;
      if (cap_en_ff) begin
         case (cap_sel_ff)
            SEL_CENTER: p_ff <= rd_data_ff;
            SEL_UP:     u_ff <= rd_data_ff;
            SEL_DOWN:   d_ff <= rd_data_ff;
            SEL_LEFT:   l_ff <= rd_data_ff;
            SEL_RIGHT:  r_ff <= rd_data_ff;
            default: ;
         endcase
      end
   end

   // ---------------- arithmetic ----------------
   logic [9:0] sum_c;
   logic [2:0] n_c;

   always_comb begin
      sum_c = '0;
      n_c   = '0;
      if (out_has_up)    begin sum_c = sum_c + 10'(thresh(u_ff, thr_ff)); n_c = n_c + 1'b1; end
      if (out_has_down)  begin sum_c = sum_c + 10'(thresh(d_ff, thr_ff)); n_c = n_c + 1'b1; end
      if (out_has_left)  begin sum_c = sum_c + 10'(thresh(l_ff, thr_ff)); n_c = n_c + 1'b1; end
      if (out_has_right) begin sum_c = sum_c + 10'(thresh(r_ff, thr_ff)); n_c = n_c + 1'b1; end
   end

   function automatic logic [10:0] spread(input logic [PIX_W-1:0] x, input logic [2:0] n,
                                          input logic [9:0] s);
      logic signed [12:0] v;
      v = 13'(x * n) - 13'(s);
      spread = (v < 0) ? 11'(-v) : 11'(v);
   endfunction

   logic [10:0] dp, du, dd, dl, dr;
   assign dp = spread(p_ff, n_ff, sum_ff);
   assign du = spread(u_ff, n_ff, sum_ff);
   assign dd = spread(d_ff, n_ff, sum_ff);
   assign dl = spread(l_ff, n_ff, sum_ff);
   assign dr = spread(r_ff, n_ff, sum_ff);

   always_ff @(posedge clock) begin
      if (cmd.calc1) begin
         sum_ff <= sum_c;
         n_ff   <= n_c;
         vu_ff  <= out_has_up;
         vd_ff  <= out_has_down;
         vl_ff  <= out_has_left;
         vr_ff  <= out_has_right;
      end
      if (cmd.calc2) begin
         farther_ff <= (vu_ff && du > dp) || (vd_ff && dd > dp) ||
                       (vl_ff && dl > dp) || (vr_ff && dr > dp);
         prod_ff    <= 20'(sum_ff) * 20'd683;
      end
   end

   // sum*256/n; divide by three via reciprocal, remainder gives the fraction
   logic [8:0]  q3;
   logic [1:0]  rem3;
   logic [15:0] avg;
   logic [15:0] center_out;

   assign q3   = prod_ff[19:11];
   assign rem3 = 2'(sum_ff - 10'(q3) * 10'd3);

   always_comb begin
      case (n_ff)
         3'd1: avg = 16'({sum_ff, 8'd0});
         3'd2: avg = 16'({sum_ff, 7'd0});
         3'd3: avg = 16'({q3, 8'd0}) + ((rem3 == 2'd2) ? 16'd170 :
                                        (rem3 == 2'd1) ? 16'd85 : 16'd0);
         3'd4: avg = 16'({sum_ff, 6'd0});
         default: avg = '0;
      endcase
   end

   assign center_out = {thresh(p_ff, thr_ff), 8'd0};

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         if ((n_ff == '0) || farther_ff) begin
            filtered_ff <= center_out;
            replaced_ff <= 1'b0;
         end else begin
            filtered_ff <= avg;
            replaced_ff <= 1'b1;
         end
         eof_ff <= row_wrap_out && col_wrap_out;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_filtered = filtered_ff;
   assign rsp_replaced = replaced_ff;
   assign rsp_eof      = eof_ff;

   assert property (@(posedge clock) disable iff (reset)
      32'(pend_ff) <= MAX_WIDTH)
      else $error("pending count overflow");
   assert property (@(posedge clock) disable iff (reset)
      (in_slot_ff != 2'd3) && (out_slot_ff != 2'd3))
      else $error("row slot out of range");
   assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("result overwritten");

endmodule

FILE: hw/rtl/neighbor_outlier_pixel_filter_unit.sv
// Neighbor outlier pixel filter, top level.
// req_ channel: one beat per pixel or drain tick; rsp_ channel: filtered pixels.
// csr_ port: write-only registers image_width, image_height, low_threshold.
// Pixels enter in raster order; the result for a pixel leaves one row later,
// so the last row is pushed out with drain ticks once the frame is complete.
// A beat that yields a result passes from acceptance to rsp_tvalid through five
// reads of the single line-store port (center and four neighbors), one capture,
// two arithmetic steps and the output load. The next beat is accepted in the
// cycle after the result is loaded, while that result may still wait on rsp_tready.
// If the receiver stalls, the finished result holds in the output register and
// the block stops before loading the next one.
// Reset clears all counters and the output valid flag; line-store contents are
// undefined until written, and values read from unwritten locations are not used.
module neighbor_outlier_pixel_filter_unit import nopf_pkg::*; #(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_DIM_W-1:0] csr_wdata,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [7:0]           req_tdata,   // [7:0] pixel
   input  logic                 req_tuser,   // [0] op
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [15:0]          rsp_tdata,   // [15:0] filtered
   output logic                 rsp_tuser,   // [0] replaced
   output logic                 rsp_tlast
);

   cmd_type    cmd;
   status_type status;

   nopf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   nopf_dpath #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_dpath (
      .clock        (clock),
      .reset        (reset),
      .csr_wr_en    (csr_wr_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .req_op       (req_tuser),
      .req_pixel    (req_tdata),
      .cmd          (cmd),
      .status       (status),
      .rsp_valid    (rsp_tvalid),
      .rsp_ready    (rsp_tready),
      .rsp_filtered (rsp_tdata),
      .rsp_replaced (rsp_tuser),
      .rsp_eof      (rsp_tlast)
   );

endmodule
